/* design/rfd_pkg.sv */
// Shared types and codes of the record format deframer.
package rfd_pkg;

  typedef enum logic [1:0] {
    FMT_FIXED     = 2'd0,
    FMT_VARIABLE  = 2'd1,
    FMT_DESC_VAR  = 2'd2,
    FMT_DESC_SPAN = 2'd3
  } format_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_VDATA = 3'd2,
    PH_TRAIL = 3'd3,
    PH_BDW   = 3'd4,
    PH_RDW   = 3'd5,
    PH_DDATA = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PARTIAL   = 3'd1,
    ST_BAD_BDW   = 3'd2,
    ST_BAD_RDW   = 3'd3,
    ST_BAD_SIZE  = 3'd4,
    ST_EXCEEDS   = 3'd5,
    ST_CLEAN_END = 3'd6
  } status_t;

  localparam logic REG_RECORD_FORMAT = 1'b0;
  localparam logic REG_FIXED_WIDTH   = 1'b1;

  localparam int unsigned DESC_BYTES = 4;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] header_shift;
    logic [1:0]  header_count;
    logic [30:0] payload_left;
    logic [30:0] lead_len;
    logic [15:0] block_remain;
    logic        seg_odd;
    logic        pending;
    logic        halted;
  } state_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       record_end;
    status_t    status;
  } result_t;

endpackage

/* design/rfd_step.sv */
// Framing logic: next state and result for one input beat.
module rfd_step (
  input  rfd_pkg::format_t fmt,
  input  logic [15:0]      fixed_width,
  input  rfd_pkg::state_t  st,
  input  logic [7:0]       data_byte,
  input  logic             end_of_file,
  output rfd_pkg::state_t  st_next,
  output rfd_pkg::result_t res,
  output logic             has_result
);

  logic [31:0] hs_le;
  logic [31:0] hs_be;
  logic [15:0] len;
  logic [15:0] size;
  logic [30:0] cnt_inc;
  logic [30:0] left_dec;
  logic        ends_rdw;
  logic        ends_st;

  assign hs_le    = {data_byte, st.header_shift[31:8]};
  assign hs_be    = {st.header_shift[23:0], data_byte};
  assign len      = hs_be[31:16];
  assign size     = len - 16'(rfd_pkg::DESC_BYTES);
  assign cnt_inc  = st.payload_left + 31'd1;
  assign left_dec = st.payload_left - 31'd1;
  assign ends_rdw = (fmt == rfd_pkg::FMT_DESC_VAR) || !hs_be[8];
  assign ends_st  = (fmt == rfd_pkg::FMT_DESC_VAR) || !st.seg_odd;

  always_comb begin
    st_next    = st;
    res        = '0;
    has_result = 1'b0;
    if (!st.halted) begin
      unique case (fmt)
        rfd_pkg::FMT_FIXED: begin
          has_result = 1'b1;
          if (end_of_file) begin
            st_next.halted = 1'b1;
            if (st.payload_left != '0) begin
              res.record_end = 1'b1;
              res.status     = rfd_pkg::ST_PARTIAL;
            end else begin
              res.status = rfd_pkg::ST_CLEAN_END;
            end
          end else begin
            res.payload_byte = data_byte;
            res.byte_valid   = 1'b1;
            if (cnt_inc >= {15'd0, fixed_width}) begin
              st_next.payload_left = '0;
              res.record_end       = 1'b1;
            end else begin
              st_next.payload_left = cnt_inc;
            end
          end
        end
        rfd_pkg::FMT_VARIABLE: begin
          if (end_of_file) begin
            has_result     = 1'b1;
            st_next.halted = 1'b1;
            if (st.phase == rfd_pkg::PH_LEAD || st.phase == rfd_pkg::PH_VDATA ||
                st.phase == rfd_pkg::PH_TRAIL) begin
              res.record_end = 1'b1;
              res.status     = rfd_pkg::ST_PARTIAL;
            end else begin
              res.status = rfd_pkg::ST_CLEAN_END;
            end
          end else begin
            case (st.phase)
              rfd_pkg::PH_LEAD: begin
                st_next.header_shift = hs_le;
                if (st.header_count < 2'd3) begin
                  st_next.header_count = st.header_count + 2'd1;
                end else begin
                  st_next.header_count = '0;
                  if (hs_le[31]) begin
                    has_result     = 1'b1;
                    st_next.halted = 1'b1;
                    res.record_end = 1'b1;
                    res.status     = rfd_pkg::ST_BAD_SIZE;
                  end else begin
                    st_next.lead_len     = hs_le[30:0];
                    st_next.payload_left = hs_le[30:0];
                    st_next.phase = (hs_le[30:0] != '0) ? rfd_pkg::PH_VDATA
                                                        : rfd_pkg::PH_TRAIL;
                  end
                end
              end
              rfd_pkg::PH_VDATA: begin
                has_result           = 1'b1;
                res.payload_byte     = data_byte;
                res.byte_valid       = 1'b1;
                st_next.payload_left = left_dec;
                if (left_dec == '0) begin
                  st_next.phase        = rfd_pkg::PH_TRAIL;
                  st_next.header_count = '0;
                end
              end
              rfd_pkg::PH_TRAIL: begin
                st_next.header_shift = hs_le;
                if (st.header_count < 2'd3) begin
                  st_next.header_count = st.header_count + 2'd1;
                end else begin
                  st_next.header_count = '0;
                  has_result           = 1'b1;
                  res.record_end       = 1'b1;
                  if (hs_le != {1'b0, st.lead_len}) begin
                    st_next.halted = 1'b1;
                    res.status     = rfd_pkg::ST_BAD_SIZE;
                  end else begin
                    st_next.phase = rfd_pkg::PH_IDLE;
                  end
                end
              end
              default: begin
                st_next.header_shift = {data_byte, 24'd0};
                st_next.header_count = 2'd1;
                st_next.phase        = rfd_pkg::PH_LEAD;
              end
            endcase
          end
        end
        default: begin
          case (st.phase)
            rfd_pkg::PH_BDW, rfd_pkg::PH_RDW: begin
              if (end_of_file) begin
                has_result     = 1'b1;
                st_next.halted = 1'b1;
                res.record_end = 1'b1;
                res.status     = rfd_pkg::ST_PARTIAL;
              end else begin
                st_next.header_shift = hs_be;
                if (st.header_count < 2'd3) begin
                  st_next.header_count = st.header_count + 2'd1;
                end else begin
                  st_next.header_count = '0;
                  if (st.phase == rfd_pkg::PH_BDW) begin
                    if (len < 16'(rfd_pkg::DESC_BYTES)) begin
                      has_result     = 1'b1;
                      st_next.halted = 1'b1;
                      res.record_end = 1'b1;
                      res.status     = rfd_pkg::ST_BAD_BDW;
                    end else if (size < 16'(rfd_pkg::DESC_BYTES)) begin
                      st_next.block_remain = size;
                      has_result           = 1'b1;
                      st_next.halted       = 1'b1;
                      res.record_end       = 1'b1;
                      res.status           = rfd_pkg::ST_PARTIAL;
                    end else begin
                      st_next.block_remain = size;
                      st_next.phase        = rfd_pkg::PH_IDLE;
                    end
                  end else if (len < 16'(rfd_pkg::DESC_BYTES)) begin
                    has_result     = 1'b1;
                    st_next.halted = 1'b1;
                    res.record_end = 1'b1;
                    res.status     = rfd_pkg::ST_BAD_RDW;
                  end else begin
                    st_next.seg_odd = hs_be[8];
                    if (size > st.block_remain) begin
                      has_result     = 1'b1;
                      st_next.halted = 1'b1;
                      res.record_end = 1'b1;
                      res.status     = rfd_pkg::ST_EXCEEDS;
                    end else begin
                      st_next.block_remain = st.block_remain - size;
                      st_next.phase        = rfd_pkg::PH_IDLE;
                      if (size == '0) begin
                        if (ends_rdw) begin
                          st_next.pending = 1'b0;
                          has_result      = 1'b1;
                          res.record_end  = 1'b1;
                        end
                      end else begin
                        st_next.payload_left = {15'd0, size};
                        st_next.phase        = rfd_pkg::PH_DDATA;
                      end
                    end
                  end
                end
              end
            end
            rfd_pkg::PH_DDATA: begin
              has_result = 1'b1;
              if (end_of_file) begin
                st_next.halted = 1'b1;
                res.record_end = 1'b1;
                res.status     = rfd_pkg::ST_PARTIAL;
              end else begin
                res.payload_byte     = data_byte;
                res.byte_valid       = 1'b1;
                st_next.payload_left = left_dec;
                st_next.pending      = 1'b1;
                if (left_dec == '0) begin
                  st_next.phase = rfd_pkg::PH_IDLE;
                  if (ends_st) begin
                    st_next.pending = 1'b0;
                    res.record_end  = 1'b1;
                  end
                end
              end
            end
            default: begin
              if (st.block_remain == '0) begin
                if (end_of_file) begin
                  has_result = 1'b1;
                  if (st.pending) begin
                    st_next.pending = 1'b0;
                    res.record_end  = 1'b1;
                  end else begin
                    st_next.halted = 1'b1;
                    res.status     = rfd_pkg::ST_CLEAN_END;
                  end
                end else begin
                  st_next.header_shift = {24'd0, data_byte};
                  st_next.header_count = 2'd1;
                  st_next.phase        = rfd_pkg::PH_BDW;
                end
              end else if (st.block_remain < 16'(rfd_pkg::DESC_BYTES) || end_of_file) begin
                has_result     = 1'b1;
                st_next.halted = 1'b1;
                res.record_end = 1'b1;
                res.status     = rfd_pkg::ST_PARTIAL;
              end else begin
                st_next.block_remain = st.block_remain - 16'(rfd_pkg::DESC_BYTES);
                st_next.header_shift = {24'd0, data_byte};
                st_next.header_count = 2'd1;
                st_next.phase        = rfd_pkg::PH_RDW;
              end
            end
          endcase
        end
      endcase
    end
  end

endmodule

/* design/rfd_out_stage.sv */
// Output register that holds one result beat until it is taken.
module rfd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rfd_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output rfd_pkg::result_t res_q
);

  logic out_valid_next;

  assign free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

/* design/record_format_deframer.sv */
// Top level of the record format deframer: input register, framing state and config.
//
//   channel  signals                                   direction
//   in       in_valid, in_ready, data_byte, end_of_file     into block
//   out      out_valid, out_ready, payload_byte, byte_valid,
//            record_end, status                          out of block
//   cfg      cfg_wen, cfg_index, cfg_data                into block
//
// One input beat is taken per cycle while the output is not stalled; the beat is held in
// the input register; its result and the next framing state are registered together.
// Reset clears the framing state and loads format 0 and record width 80.
// A stalled output holds the input register; in_ready drops only while both registers
// are full and out_ready is low.
module record_format_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic        record_end,
  output logic [2:0]  status,
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  rfd_pkg::format_t fmt;
  logic [15:0]      fixed_width;
  rfd_pkg::state_t  st;
  rfd_pkg::state_t  st_next;
  rfd_pkg::state_t  st_step;
  rfd_pkg::result_t res;
  rfd_pkg::result_t res_q;
  logic             has_result;
  logic             iq_valid;
  logic [7:0]       iq_byte;
  logic             iq_eof;
  logic             fire;
  logic             out_free;

  assign fire     = iq_valid && out_free;
  assign in_ready = !iq_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (in_ready) begin
      iq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      iq_byte <= data_byte;
      iq_eof  <= end_of_file;
    end
  end

  rfd_step u_step (
    .fmt         (fmt),
    .fixed_width (fixed_width),
    .st          (st),
    .data_byte   (iq_byte),
    .end_of_file (iq_eof),
    .st_next     (st_step),
    .res         (res),
    .has_result  (has_result)
  );

  always_comb begin
    st_next = st;
    if (cfg_wen && cfg_index == rfd_pkg::REG_RECORD_FORMAT) begin
      st_next        = '0;
      st_next.halted = st.halted;
    end else if (fire) begin
      st_next = st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      fmt         <= rfd_pkg::FMT_FIXED;
      fixed_width <= 16'd80;
    end else begin
      st <= st_next;
      if (cfg_wen) begin
        unique case (cfg_index)
          rfd_pkg::REG_RECORD_FORMAT: fmt         <= rfd_pkg::format_t'(cfg_data[1:0]);
          rfd_pkg::REG_FIXED_WIDTH:   fixed_width <= cfg_data;
          default:                    fixed_width <= fixed_width;
        endcase
      end
    end
  end

  rfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && has_result),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .res_q     (res_q)
  );

  assign payload_byte = res_q.payload_byte;
  assign byte_valid   = res_q.byte_valid;
  assign record_end   = res_q.record_end;
  assign status       = res_q.status;

`ifndef ASSERT_OFF
  a_halted_silent : assert property (@(posedge clk) disable iff (rst)
    st.halted && fire |-> !has_result)
    else $error("Halted deframer produced a result.");

  a_result_lands : assert property (@(posedge clk) disable iff (rst)
    fire && has_result |=> out_valid)
    else $error("Result was not registered at the output.");

  a_halt_on_error : assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.status != rfd_pkg::ST_OK && !cfg_wen |=> st.halted)
    else $error("Error or clean end did not halt the deframer.");

  a_data_phase_count : assert property (@(posedge clk) disable iff (rst)
    st.phase == rfd_pkg::PH_DDATA || st.phase == rfd_pkg::PH_VDATA |->
      st.payload_left != '0)
    else $error("Payload phase entered with no bytes due.");
`endif

endmodule
